// ----- sv/bys_pkg.sv -----
// ----------------------------------------------------------------------------
// Bisection yield solver package
// Widths, reset values, register indexes and controller states shared by the
// solver and its serial arithmetic units.
// ----------------------------------------------------------------------------
package bys_pkg;

  localparam int unsigned RATE_W   = 24;              // Q0.24 rate
  localparam int unsigned MONEY_W  = 32;              // Q.8 money
  localparam int unsigned FACT_W   = RATE_W + 2;      // Q2.24 discount factor
  localparam int unsigned OPND_W   = RATE_W + 1;      // 1 + rate
  localparam int unsigned PROD_W   = 2 * OPND_W;
  localparam int unsigned QUOT_W   = MONEY_W + 1;     // signed quotient
  localparam int unsigned SUM_W    = MONEY_W + 3;     // sum of three terms less target
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] HALVING_LIMIT = CNT_W'(24);
  localparam logic [1:0]       MAX_FLOWS     = 2'd3;

  localparam logic [MONEY_W-1:0] FLOW_ZERO_RST = 32'sd2483712;
  localparam logic [MONEY_W-1:0] FLOW_ONE_RST  = -32'sd5043200;
  localparam logic [MONEY_W-1:0] FLOW_TWO_RST  = 32'sd2560000;
  localparam logic [MONEY_W-1:0] TARGET_RST    = '0;
  localparam logic [1:0]         COUNT_RST     = 2'd3;
  localparam logic [RATE_W-1:0]  TOL_RST       = RATE_W'(1678);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOW_ZERO = 3'd0,
    CFG_FLOW_ONE  = 3'd1,
    CFG_FLOW_TWO  = 3'd2,
    CFG_TARGET    = 3'd3,
    CFG_COUNT     = 3'd4,
    CFG_TOL       = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV1,
    ST_MUL,
    ST_DIV2,
    ST_DECIDE,
    ST_DONE
  } state_e;

endpackage

// ----- sv/bys_mul.sv -----
// ----------------------------------------------------------------------------
// Bisection yield solver: serial squarer
// Shift-add multiplier, one multiplier bit per cycle, squares 1 + rate.
// ----------------------------------------------------------------------------
module bys_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bys_pkg::OPND_W-1:0]  op_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [bys_pkg::PROD_W-1:0]  prod_o
);
  import bys_pkg::*;

  logic [PROD_W-1:0] p_q, p_d;
  logic [OPND_W-1:0] a_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [OPND_W:0]   sum;

  // add the multiplicand when the low bit is set, then shift right
  always_comb begin
    sum = {1'b0, p_q[PROD_W-1:OPND_W]} + (p_q[0] ? {1'b0, a_q} : '0);
    p_d = {sum, p_q[OPND_W-1:1]};
  end

  // control: count one bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(OPND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= op_i;
      p_q <= {{OPND_W{1'b0}}, op_i};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

// ----- sv/bys_div.sv -----
// ----------------------------------------------------------------------------
// Bisection yield solver: serial divider
// Restoring divider, one quotient bit per cycle, forms flow * 2^24 / factor
// rounded toward zero.
// ----------------------------------------------------------------------------
module bys_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [bys_pkg::MONEY_W-1:0] flow_i,
  input  logic [bys_pkg::FACT_W-1:0]         divisor_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic signed [bys_pkg::QUOT_W-1:0]  quot_o
);
  import bys_pkg::*;

  logic [FACT_W-1:0]  rem_q, rem_d;
  logic [FACT_W-1:0]  dvs_q;
  logic [MONEY_W-1:0] sh_q, quo_q;
  logic               neg_q, busy_q, done_q, ge;
  logic [CNT_W-1:0]   cnt_q;
  logic [MONEY_W-1:0] mag;
  logic [FACT_W:0]    trial, diff;

  // magnitude of the flow; the most negative flow fits unsigned
  assign mag = flow_i[MONEY_W-1] ? MONEY_W'(-flow_i) : flow_i;

  // one restoring step: shift in a dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_q, sh_q[MONEY_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? diff[FACT_W-1:0] : trial[FACT_W-1:0];
  end

  // control: one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MONEY_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath: the top dividend bits are below the divisor, so preload them
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {2'b00, mag[MONEY_W-1:8]};
      sh_q  <= {mag[7:0], {RATE_W{1'b0}}};
      quo_q <= '0;
      neg_q <= flow_i[MONEY_W-1];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      sh_q  <= {sh_q[MONEY_W-2:0], 1'b0};
      quo_q <= {quo_q[MONEY_W-2:0], ge};
    end
  end

  assign quot_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ----- sv/bisection_yield_solver.sv -----
// ----------------------------------------------------------------------------
// Bisection yield solver
// Bisects a rate interval for the rate at which the discounted cash flows
// meet a target value; returns the final upper bound.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  in      | in_valid_i / in_stall_o| lower_bound_i, upper_bound_i, rising_mode_i
//  out     | out_valid_o/out_stall_i| yield_rate_o
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  Each halving runs one check, two serial divisions (32 quotient bits and
//  a handover each), a serial squaring (25 multiplier bits and a handover)
//  and one decide step.
//  A command runs at most 24 halvings from its beat to its result, then a
//  final check and the output load.
//  Reset clears control state; registers return to their reset values.
//  A command is taken only in idle; a result waits in the output register
//  while the next command is accepted.
// ----------------------------------------------------------------------------
module bisection_yield_solver (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bys_pkg::RATE_W-1:0]       lower_bound_i,
  input  logic [bys_pkg::RATE_W-1:0]       upper_bound_i,
  input  logic                             rising_mode_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bys_pkg::RATE_W-1:0]       yield_rate_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bys_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bys_pkg::MONEY_W-1:0]      cfg_data_i
);
  import bys_pkg::*;

  state_e state_q, state_d;

  logic [MONEY_W-1:0] flow_zero_q, flow_one_q, flow_two_q, target_q;
  logic [1:0]         count_q;
  logic [RATE_W-1:0]  tol_q;

  logic [RATE_W-1:0]  lo_q, hi_q, mid_q, yield_q;
  logic               rising_q, out_valid_q;
  logic [CNT_W-1:0]   hcnt_q;
  logic signed [SUM_W-1:0] sum_q;

  logic               go, div_start, mul_start, load_out;
  logic [RATE_W:0]    mid_sum;
  logic [RATE_W-1:0]  mid;
  logic signed [MONEY_W-1:0] div_flow;
  logic [FACT_W-1:0]  div_dvs;
  logic               div_busy, div_done, mul_busy, mul_done;
  logic signed [QUOT_W-1:0]  quot;
  logic [PROD_W-1:0]  prod;
  logic signed [SUM_W-1:0]   excess;
  logic [1:0]         eff_count;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_zero_q <= FLOW_ZERO_RST;
      flow_one_q  <= FLOW_ONE_RST;
      flow_two_q  <= FLOW_TWO_RST;
      target_q    <= TARGET_RST;
      count_q     <= COUNT_RST;
      tol_q       <= TOL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FLOW_ZERO: flow_zero_q <= cfg_data_i;
        CFG_FLOW_ONE:  flow_one_q  <= cfg_data_i;
        CFG_FLOW_TWO:  flow_two_q  <= cfg_data_i;
        CFG_TARGET:    target_q    <= cfg_data_i;
        CFG_COUNT:     count_q     <= cfg_data_i[1:0];
        CFG_TOL:       tol_q       <= cfg_data_i[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // interval test and midpoint
  assign eff_count = (count_q > MAX_FLOWS) ? MAX_FLOWS : count_q;
  assign go = (hi_q >= lo_q) && ((hi_q - lo_q) >= tol_q) && (hcnt_q < HALVING_LIMIT);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid = mid_sum[RATE_W:1];
  assign excess = sum_q - SUM_W'($signed(target_q));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CHECK;
      ST_CHECK:  state_d = go ? ST_DIV1 : ST_DONE;
      ST_DIV1:   if (div_done) state_d = ST_MUL;
      ST_MUL:    if (mul_done) state_d = ST_DIV2;
      ST_DIV2:   if (div_done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_CHECK;
      ST_DONE:   if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // unit starts and operand selection
  always_comb begin
    div_start = 1'b0;
    mul_start = 1'b0;
    load_out  = 1'b0;
    div_flow  = $signed(flow_one_q);
    div_dvs   = {2'b01, mid};
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE:  in_stall_o = 1'b0;
      ST_CHECK: div_start = go;
      ST_DIV1:  mul_start = div_done;
      ST_MUL: begin
        div_start = mul_done;
        div_flow  = $signed(flow_two_q);
        div_dvs   = prod[PROD_W-1:RATE_W];
      end
      ST_DONE:  load_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // state register and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // search datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q     <= '0;
      hi_q     <= '0;
      mid_q    <= '0;
      hcnt_q   <= '0;
      sum_q    <= '0;
      rising_q <= 1'b0;
      yield_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            lo_q     <= lower_bound_i;
            hi_q     <= upper_bound_i;
            rising_q <= rising_mode_i;
            hcnt_q   <= '0;
          end
        end
        ST_CHECK: begin
          if (go) begin
            mid_q <= mid;
            sum_q <= (eff_count != 2'd0) ? SUM_W'($signed(flow_zero_q)) : '0;
          end
        end
        ST_DIV1: if (div_done && eff_count >= 2'd2) sum_q <= sum_q + SUM_W'(quot);
        ST_DIV2: if (div_done && eff_count == 2'd3) sum_q <= sum_q + SUM_W'(quot);
        ST_DECIDE: begin
          if ((excess > 0) != rising_q) hi_q <= mid_q;
          else lo_q <= mid_q;
          hcnt_q <= hcnt_q + 1'b1;
        end
        ST_DONE: if (load_out) yield_q <= hi_q;
        default: ;
      endcase
    end
  end

  bys_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .flow_i    (div_flow),
    .divisor_i (div_dvs),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  bys_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .op_i    ({1'b1, mid_q}),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign out_valid_o  = out_valid_q;
  assign yield_rate_o = yield_q;

`ifndef SYNTHESIS
  // never more halvings than the guard
  a_hcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= HALVING_LIMIT) else $error("halving count past guard");

  // the two serial units never run together
  a_units_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_busy && mul_busy)) else $error("divider and squarer both busy");

  // the interval stays ordered while a halving is in flight
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV1 || state_q == ST_MUL || state_q == ST_DIV2 ||
     state_q == ST_DECIDE) |-> (lo_q <= mid_q && mid_q <= hi_q))
    else $error("trial rate outside interval");

  // a finished first division always hands over to the squarer
  a_div_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_done && state_q == ST_DIV1) |=> (state_q == ST_MUL && mul_busy))
    else $error("squarer not started after first division");
`endif

endmodule

// ----- tb/bisection_yield_solver_checker.sv -----
// ----------------------------------------------------------------------------
// Bisection yield solver checker
// Watches the configuration, command and result channels, predicts each
// yield rate from a shadow copy of the registers and compares in order.
// ----------------------------------------------------------------------------
module bisection_yield_solver_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [bys_pkg::RATE_W-1:0]     lower_bound_i,
  input  logic [bys_pkg::RATE_W-1:0]     upper_bound_i,
  input  logic                           rising_mode_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [bys_pkg::RATE_W-1:0]     yield_rate_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [bys_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bys_pkg::MONEY_W-1:0]    cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             results_seen_o
);
  import bys_pkg::*;

  logic signed [31:0] flow_r [3];
  logic signed [31:0] target_r;
  logic [1:0]         count_r;
  logic [23:0]        tol_r;
  logic [23:0]        expected_rates [$];

  assign pending_o = expected_rates.size();

  // Present value at a trial rate, minus the target
  function automatic longint signed rate_excess(logic [23:0] rate);
    longint signed  sum;
    longint unsigned fact;
    int n;
    sum  = 0;
    fact = 64'd1 << 24;
    n    = (count_r > MAX_FLOWS) ? MAX_FLOWS : count_r;
    for (int i = 0; i < n; i++) begin
      sum  += (longint'(flow_r[i]) * (64'sd1 <<< 24)) / longint'(fact);
      fact = (fact * ((64'd1 << 24) + rate)) >> 24;
    end
    return sum - longint'(target_r);
  endfunction

  // Bisect the interval as the block does
  function automatic logic [23:0] solve_yield(logic [23:0] lo_in, logic [23:0] hi_in,
                                              logic rising);
    logic [23:0] lo, hi, mid;
    int halvings;
    lo = lo_in;
    hi = hi_in;
    halvings = 0;
    while (hi >= lo && (hi - lo) >= tol_r && halvings < 24) begin
      mid = 24'((25'(lo) + 25'(hi)) >> 1);
      if ((rate_excess(mid) > 0) != rising) hi = mid;
      else lo = mid;
      halvings++;
    end
    return hi;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o   = 0;
    results_seen_o = 0;
  end

  // Track registers, queue predictions, compare result beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_r[0] <= FLOW_ZERO_RST;
      flow_r[1] <= FLOW_ONE_RST;
      flow_r[2] <= FLOW_TWO_RST;
      target_r  <= TARGET_RST;
      count_r   <= COUNT_RST;
      tol_r     <= TOL_RST;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FLOW_ZERO: flow_r[0] <= cfg_data_i;
          CFG_FLOW_ONE:  flow_r[1] <= cfg_data_i;
          CFG_FLOW_TWO:  flow_r[2] <= cfg_data_i;
          CFG_TARGET:    target_r  <= cfg_data_i;
          CFG_COUNT:     count_r   <= cfg_data_i[1:0];
          CFG_TOL:       tol_r     <= cfg_data_i[23:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_rates.push_back(solve_yield(lower_bound_i, upper_bound_i, rising_mode_i));
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (expected_rates.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", yield_rate_i));
        end else begin
          if (yield_rate_i !== expected_rates[0])
            report_mismatch($sformatf("yield_rate %h, predicted %h",
                                      yield_rate_i, expected_rates[0]));
          void'(expected_rates.pop_front());
        end
      end
    end
  end
endmodule

// ----- tb/tb_bisection_yield_solver.sv -----
// ----------------------------------------------------------------------------
// Bisection yield solver testbench
// Drives directed and random search commands under several register settings
// with random gaps and stalls; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_bisection_yield_solver;
  import bys_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [RATE_W-1:0] lower_bound_i = '0;
  logic [RATE_W-1:0] upper_bound_i = '0;
  logic rising_mode_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [RATE_W-1:0] yield_rate_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [MONEY_W-1:0] cfg_data_i = '0;
  int fail_count, pending, results_seen;
  int commands_sent = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  always #5 clk_i = ~clk_i;

  bisection_yield_solver i_dut (.*);

  bisection_yield_solver_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .lower_bound_i,
    .upper_bound_i, .rising_mode_i, .out_valid_i(out_valid_o), .out_stall_i,
    .yield_rate_i(yield_rate_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending),
    .results_seen_o(results_seen)
  );

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
  endfunction

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (6000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      n = gap_len();
      out_stall_i <= (n != 0);
      repeat (n > 0 ? n : 1) @(posedge clk_i);
      out_stall_i <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold the beat until accepted; with gaps set, sometimes gap before the next one
  task automatic send_command(logic [23:0] lo, logic [23:0] hi, logic rising, bit gaps);
    lower_bound_i <= lo;
    upper_bound_i <= hi;
    rising_mode_i <= rising;
    in_valid_i    <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    commands_sent++;
    if (gaps && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_len() + 1) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [23:0] rand_rate();
    case ($urandom_range(0, 4))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic random_setting(int phase);
    case (phase % 4)
      0: begin
        write_reg(CFG_FLOW_ZERO, 32'($urandom_range(0, 200000) * 256));
        write_reg(CFG_FLOW_ONE, -32'($urandom_range(0, 400000) * 256));
        write_reg(CFG_FLOW_TWO, 32'($urandom_range(0, 200000) * 256));
      end
      1: begin
        write_reg(CFG_FLOW_ZERO, $urandom());
        write_reg(CFG_FLOW_ONE, $urandom());
        write_reg(CFG_FLOW_TWO, $urandom());
      end
      2: begin
        write_reg(CFG_FLOW_ZERO, 32'h8000_0000);
        write_reg(CFG_FLOW_ONE, 32'h7FFF_FFFF);
        write_reg(CFG_FLOW_TWO, 32'h8000_0000);
      end
      default: begin
        write_reg(CFG_FLOW_ZERO, 32'h7FFF_FFFF);
        write_reg(CFG_FLOW_ONE, 32'h8000_0000);
        write_reg(CFG_FLOW_TWO, 32'h7FFF_FFFF);
      end
    endcase
    write_reg(CFG_TARGET, ($urandom_range(0, 3) == 0) ? $urandom() :
                          32'($signed($urandom_range(0, 20000)) - 10000));
    write_reg(CFG_COUNT, $urandom_range(0, 3));
    case ($urandom_range(0, 4))
      0: write_reg(CFG_TOL, 32'd0);
      1: write_reg(CFG_TOL, 32'hFF_FFFF);
      2: write_reg(CFG_TOL, 32'd1);
      default: write_reg(CFG_TOL, $urandom_range(1, 100000));
    endcase
    // Index beyond the register list is ignored
    write_reg(cfg_idx_e'(3'd6 + 3'($urandom_range(0, 1))), $urandom());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, extreme bounds, both modes, inverted interval
    send_command(24'h0, 24'hFFFFFF, 1'b0, 1'b0);
    send_command(24'h0, 24'hFFFFFF, 1'b1, 1'b0);
    send_command(24'h0, 24'h0, 1'b0, 1'b0);
    send_command(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0);
    send_command(24'h100, 24'h80, 1'b0, 1'b0);
    send_command(24'hFFFFFF, 24'h0, 1'b1, 1'b0);
    send_command(24'h0, 24'h19999A, 1'b0, 1'b0);
    drain();
    // Zero tolerance, zero flow count, extreme flows and target
    write_reg(CFG_TOL, 32'd0);
    write_reg(CFG_COUNT, 32'd0);
    send_command(24'h0, 24'hFFFFFF, 1'b0, 1'b0);
    send_command(24'h0, 24'hFFFFFF, 1'b1, 1'b0);
    drain();
    write_reg(CFG_FLOW_ZERO, 32'h7FFF_FFFF);
    write_reg(CFG_FLOW_ONE, 32'h8000_0000);
    write_reg(CFG_FLOW_TWO, 32'h7FFF_FFFF);
    write_reg(CFG_TARGET, 32'h8000_0000);
    write_reg(CFG_COUNT, 32'd3);
    write_reg(CFG_TOL, 32'hFF_FFFF);
    send_command(24'h0, 24'hFFFFFF, 1'b0, 1'b0);
    send_command(24'h0, 24'h7FFFFF, 1'b1, 1'b0);
    drain();
    write_reg(CFG_TARGET, 32'h7FFF_FFFF);
    write_reg(CFG_TOL, 32'd1);
    write_reg(CFG_COUNT, 32'd2);
    send_command(24'h0, 24'hFFFFFF, 1'b0, 1'b0);
    send_command(24'h0, 24'hFFFFFF, 1'b1, 1'b0);
    drain();
    write_reg(CFG_COUNT, 32'd1);
    send_command(24'h0, 24'hFFFFFF, 1'b1, 1'b0);
    drain();

    // Random phases; fill the block under a long hold-off in one of them
    for (int phase = 0; phase < 12; phase++) begin
      random_setting(phase);
      if (phase == 3) hold_off = 1'b1;
      for (int k = 0; k < 125; k++)
        send_command(rand_rate(), rand_rate(), 1'($urandom()), 1'b1);
      drain();
    end

    $display("Ran %0d commands over 12 random register settings, %0d results checked",
             commands_sent, results_seen);
    $display("Covered inverted intervals, zero tolerance, zero and full flow counts");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
